// ===== rtl/escd_pkg.sv =====
// Shared types, constants and byte-class functions for the escape codec.
`default_nettype none
package escd_pkg;

  localparam logic [7:0] LeadLow   = 8'h81;
  localparam logic [7:0] LeadHigh  = 8'hfe;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChN       = 8'h6e;
  localparam logic [7:0] ChComma   = 8'h2c;
  localparam logic [7:0] ChC       = 8'h63;
  localparam logic [7:0] ChBar     = 8'h7c;
  localparam logic [7:0] ChZ       = 8'h7a;
  localparam logic [7:0] ChBslash  = 8'h5c;
  localparam logic [7:0] ChY       = 8'h79;
  localparam logic [7:0] ChNone    = 8'h00;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  // Queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One queued transaction: one or two output bytes
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } escd_entry_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } escd_qstat_t;

  function automatic logic is_lead(input logic [7:0] b);
    return (b > LeadLow) && (b < LeadHigh);
  endfunction

  function automatic logic [7:0] escape_letter(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      ChNewline: r = ChN;
      ChComma:   r = ChC;
      ChBar:     r = ChZ;
      ChBslash:  r = ChY;
      default:   r = ChNone;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      ChN:     r = ChNewline;
      ChC:     r = ChComma;
      ChZ:     r = ChBar;
      ChY:     r = ChBslash;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/escape_codec_dbcs_core.sv =====
// An accepted input transaction reaches the output through the work queue and then the output register.
// Throughput: one input per cycle while in_stall_o is low; an escape pair holds the output stage
// for both of its bytes, as the single-byte output register drains the two-entry work queue.
// Reset: asynchronous, active low; clears per-string state, the queue and output valid,
// mode to encode and out_capacity to 256. No clearing pass is needed.
// Top level of the double-byte aware backslash escape codec.
`default_nettype none
module escape_codec_dbcs_core #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        is_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o
);
  import escd_pkg::*;

  localparam logic RegMode = 1'b0;
  localparam logic RegCap  = 1'b1;

  logic        mode_q;
  logic [15:0] cap_q;
  logic        cfg_wr, in_acc, push, pop;
  escd_entry_t push_entry, head_entry;
  escd_qstat_t qstat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegCap) ? {16'b0, cap_q} : {31'b0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeEncode;
      cap_q  <= 16'd256;
    end else if (cfg_wr) begin
      if (paddr[2] == RegMode) mode_q <= pwdata[0];
      else                     cap_q  <= pwdata[15:0];
    end
  end

  assign in_stall_o = qstat.full;
  assign in_acc     = in_valid_i && !in_stall_o;

  escd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .cap_i       (cap_q),
    .acc_i       (in_acc),
    .data_byte_i (data_byte_i),
    .is_end_i    (is_end_i),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  escd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (qstat)
  );

  escd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .empty_i     (qstat.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

`ifndef SYNTHESIS
  a_qcount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= QCntW'(QDepth))
    else $error("work queue count exceeds depth");

  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |-> (out_byte_o == ChNone))
    else $error("terminator carries a non-zero byte");

  a_end_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_end_i) |=> !qstat.empty)
    else $error("end transaction not queued");
`endif

endmodule
`default_nettype wire

// ===== rtl/escd_front.sv =====
// Front end: accepts input bytes, tracks per-string state, queues output work.
`default_nettype none
module escd_front #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 mode_i,
  input  wire logic [15:0]          cap_i,
  input  wire logic                 acc_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 is_end_i,
  output logic                      push_o,
  output escd_pkg::escd_entry_t     entry_o
);
  import escd_pkg::*;

  localparam int CmpW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;

  logic [COUNT_BITS-1:0] wc_q, wc_d;
  logic                  trail_q, trail_d;
  logic                  esc_q, esc_d;
  logic                  stop_q, stop_d;

  logic [CmpW-1:0] wc_ext, cap_ext, lim, eff_cap, wc1, wc2;
  logic [7:0]      letter;
  logic            lead;

  assign wc_ext  = CmpW'(wc_q);
  assign cap_ext = CmpW'(cap_i);
  assign lim     = CmpW'(1) << COUNT_BITS;
  assign eff_cap = (cap_ext < lim) ? cap_ext : lim;
  assign wc1     = wc_ext + CmpW'(1);
  assign wc2     = wc_ext + CmpW'(2);
  assign letter  = escape_letter(data_byte_i);
  assign lead    = is_lead(data_byte_i);

  always_comb begin
    wc_d    = wc_q;
    trail_d = trail_q;
    esc_d   = esc_q;
    stop_d  = stop_q;
    push_o  = 1'b0;
    entry_o = '{two: 1'b0, b0: data_byte_i, b1: letter, last: 1'b0};
    if (acc_i) begin
      if (is_end_i) begin
        push_o     = 1'b1;
        entry_o.b0 = ChNone;
        entry_o.last = 1'b1;
        wc_d    = '0;
        trail_d = 1'b0;
        esc_d   = 1'b0;
        stop_d  = 1'b0;
      end else if (mode_i == ModeDecode) begin
        if (esc_q) begin
          esc_d      = 1'b0;
          push_o     = 1'b1;
          entry_o.b0 = unescape(data_byte_i);
        end else if (trail_q) begin
          trail_d = 1'b0;
          push_o  = 1'b1;
        end else if (lead) begin
          trail_d = 1'b1;
          push_o  = 1'b1;
        end else if (data_byte_i == ChBslash) begin
          esc_d = 1'b1;
        end else begin
          push_o = 1'b1;
        end
      end else if (!stop_q) begin
        if (trail_q) begin
          trail_d = 1'b0;
          wc_d    = wc1[COUNT_BITS-1:0];
          push_o  = 1'b1;
        end else if (wc1 >= eff_cap) begin
          stop_d = 1'b1;
        end else if ((lead || (letter != ChNone)) && (wc2 >= eff_cap)) begin
          stop_d = 1'b1;
        end else if (lead) begin
          trail_d = 1'b1;
          wc_d    = wc1[COUNT_BITS-1:0];
          push_o  = 1'b1;
        end else if (letter != ChNone) begin
          // escape pair: backslash then letter
          wc_d        = wc2[COUNT_BITS-1:0];
          push_o      = 1'b1;
          entry_o.two = 1'b1;
          entry_o.b0  = ChBslash;
        end else begin
          wc_d   = wc1[COUNT_BITS-1:0];
          push_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q    <= '0;
      trail_q <= 1'b0;
      esc_q   <= 1'b0;
      stop_q  <= 1'b0;
    end else begin
      wc_q    <= wc_d;
      trail_q <= trail_d;
      esc_q   <= esc_d;
      stop_q  <= stop_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/escd_fifo.sv =====
// Short work queue between the front end and the output stage.
`default_nettype none
module escd_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire escd_pkg::escd_entry_t entry_i,
  input  wire logic                  pop_i,
  output escd_pkg::escd_entry_t      entry_o,
  output escd_pkg::escd_qstat_t      stat_o
);
  import escd_pkg::*;

  escd_entry_t      mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign entry_o      = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + QCntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - QCntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/escd_back.sv =====
// Back end: drains queued work into the registered output, one byte at a time (two for an escape pair).
`default_nettype none
module escd_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire escd_pkg::escd_entry_t entry_i,
  input  wire logic                  empty_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       out_last_o
);
  import escd_pkg::*;

  logic       valid_q, sec_q;
  logic [7:0] byte_q, sec_byte_q;
  logic       last_q;
  logic       load;

  assign load        = !valid_q || !out_stall_i;
  assign pop_o       = load && !sec_q && !empty_i;
  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sec_q   <= 1'b0;
    end else if (load) begin
      if (sec_q) begin
        valid_q <= 1'b1;
        sec_q   <= 1'b0;
      end else begin
        valid_q <= !empty_i;
        sec_q   <= !empty_i && entry_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sec_q) begin
        // second byte of an escape pair
        byte_q <= sec_byte_q;
        last_q <= 1'b0;
      end else if (!empty_i) begin
        byte_q     <= entry_i.b0;
        last_q     <= entry_i.last;
        sec_byte_q <= entry_i.b1;
      end
    end
  end

endmodule
`default_nettype wire
